/* rtl/core/strq_pkg.sv */
// Shared field widths and operation codes for the sparse table range query unit.
`default_nettype none
package strq_pkg;

   localparam int unsigned OP_W        = 1;
   localparam int unsigned IN_VALUE_W  = 32;
   localparam int unsigned FIRST_W     = 10;
   localparam int unsigned END_W       = 11;
   localparam int unsigned OUT_INDEX_W = 10;
   localparam int unsigned QLVL_W      = $clog2(END_W);

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_LOAD  = 1'b0;
   localparam op_type OP_QUERY = 1'b1;

endpackage
`default_nettype wire

/* rtl/core/sparse_table_range_extreme_query_unit.sv */
// Top level of the sparse table range minimum/maximum query unit.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------------
//  req     | in        | req_valid / req_stall  | op, value, final_value, range_first, range_end
//  rsp     | out       | rsp_valid / rsp_stall  | best_index, best_value, query_error
//  csr     | in        | csr_valid / csr_ready  | mode
//
//  A load is taken in the idle state. A query holds req_stall through the table read, the
//  element read and the shared compare unit, a refused query through the compare alone, plus
//  any wait for the result register to drain.
//  A final load of two or more elements builds the table one entry at a time, sum over levels
//  L >= 1 of (count - 2^L + 1) entries, limited by the single compare unit and table write port.
//  Reset is synchronous: it clears the count, the built flag, mode and the result valid.
//  req_stall is high while a query or a build is in flight; rsp_stall holds the result.
`default_nettype none
module sparse_table_range_extreme_query_unit #(
   parameter int unsigned MAX_ELEMENTS = 1024,
   parameter int unsigned LEVELS       = 11,
   parameter int unsigned VALUE_WIDTH  = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic [strq_pkg::OP_W-1:0]                req_op,
   input  wire logic signed [strq_pkg::IN_VALUE_W-1:0]   req_value,
   input  wire logic                                     req_final_value,
   input  wire logic [strq_pkg::FIRST_W-1:0]             req_range_first,
   input  wire logic [strq_pkg::END_W-1:0]               req_range_end,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic [strq_pkg::OUT_INDEX_W-1:0]              rsp_best_index,
   output logic signed [strq_pkg::IN_VALUE_W-1:0]        rsp_best_value,
   output logic                                          rsp_query_error,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic                                     csr_mode
);

   localparam int unsigned IDX_W     = $clog2(MAX_ELEMENTS);
   localparam int unsigned CNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int unsigned TLV_W     = $clog2(LEVELS);
   localparam int unsigned SPW       = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;
   localparam int unsigned EW        = (CNT_W > strq_pkg::END_W) ? CNT_W : strq_pkg::END_W;
   localparam int unsigned TAW       = TLV_W + IDX_W;
   localparam int unsigned TBL_DEPTH = LEVELS << IDX_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TBL  = 2'd1;
   localparam logic [1:0] ST_ELM  = 2'd2;
   localparam logic [1:0] ST_CMP  = 2'd3;

   logic [VALUE_WIDTH-1:0] elem_mem [MAX_ELEMENTS];
   logic [IDX_W-1:0]       tbl_mem  [TBL_DEPTH];

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ready_ff, ready_in;
   logic                   mode_ff, mode_in;
   logic                   build_mode_ff, build_mode_in;
   logic                   build_ff, build_in;
   logic                   err_ff, err_in;
   logic [TLV_W-1:0]       rd_lvl_ff, rd_lvl_in;
   logic [TLV_W-1:0]       wr_lvl_ff, wr_lvl_in;
   logic [IDX_W-1:0]       rd_a_ff, rd_a_in;
   logic [IDX_W-1:0]       rd_b_ff, rd_b_in;
   logic [IDX_W-1:0]       tda_ff, tdb_ff;
   logic [IDX_W-1:0]       ea_ff, eb_ff;
   logic [VALUE_WIDTH-1:0] va_ff, vb_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [strq_pkg::OUT_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [strq_pkg::IN_VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                   rsp_err_ff, rsp_err_in;

   logic                   req_accept;
   logic [IDX_W-1:0]       ea_sel, eb_sel;
   logic [IDX_W-1:0]       best_idx;
   logic [VALUE_WIDTH-1:0] best_val;
   logic                   elem_we;
   logic [IDX_W-1:0]       elem_waddr;
   logic                   tbl_we;
   logic [CNT_W-1:0]       base_cnt;
   logic [strq_pkg::END_W-1:0]  q_len, q_b_pos;
   logic [strq_pkg::QLVL_W-1:0] q_lvl;
   logic                   q_bad;
   logic [SPW-1:0]         span, next_pos_end, n_wide;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_index  = rsp_index_ff;
   assign rsp_best_value  = rsp_value_ff;
   assign rsp_query_error = rsp_err_ff;

   assign ea_sel = (rd_lvl_ff == '0) ? rd_a_ff : tda_ff;
   assign eb_sel = (rd_lvl_ff == '0) ? rd_b_ff : tdb_ff;

   strq_pick #(
      .IDX_W       (IDX_W),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_pick (
      .max_mode (build_mode_ff),
      .idx_a    (ea_ff),
      .idx_b    (eb_ff),
      .val_a    (va_ff),
      .val_b    (vb_ff),
      .best_idx (best_idx),
      .best_val (best_val)
   );

   always_comb begin
      q_len = req_range_end - strq_pkg::END_W'(req_range_first);
      q_lvl = '0;
      for (int i = 0; i < strq_pkg::END_W; i++) begin
         if (q_len[i]) begin
            q_lvl = strq_pkg::QLVL_W'(i);
         end
      end
      q_b_pos = req_range_end - (strq_pkg::END_W'(1) << q_lvl);
      q_bad   = !ready_ff
             || (strq_pkg::END_W'(req_range_first) >= req_range_end)
             || (EW'(req_range_end) > EW'(count_ff))
             || (SPW'(q_lvl) >= SPW'(LEVELS));
   end

   always_comb begin
      span         = SPW'(1) << wr_lvl_ff;
      n_wide       = SPW'(count_ff);
      next_pos_end = SPW'(rd_a_ff) + SPW'(1) + span;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ready_in      = ready_ff;
      mode_in       = mode_ff;
      build_mode_in = build_mode_ff;
      build_in      = build_ff;
      err_in        = err_ff;
      rd_lvl_in     = rd_lvl_ff;
      wr_lvl_in     = wr_lvl_ff;
      rd_a_in       = rd_a_ff;
      rd_b_in       = rd_b_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_err_in    = rsp_err_ff;
      elem_we       = 1'b0;
      tbl_we        = 1'b0;
      base_cnt      = ready_ff ? '0 : count_ff;
      elem_waddr    = IDX_W'(base_cnt);

      if (csr_valid && csr_ready) begin
         mode_in = csr_mode;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_op == strq_pkg::OP_LOAD) begin
                  ready_in = 1'b0;
                  count_in = base_cnt;
                  if (base_cnt < CNT_W'(MAX_ELEMENTS)) begin
                     elem_we  = 1'b1;
                     count_in = base_cnt + CNT_W'(1);
                  end
                  if (req_final_value) begin
                     ready_in      = 1'b1;
                     build_mode_in = mode_ff;
                     if (count_in >= CNT_W'(2)) begin
                        build_in  = 1'b1;
                        wr_lvl_in = TLV_W'(1);
                        rd_lvl_in = '0;
                        rd_a_in   = '0;
                        rd_b_in   = IDX_W'(1);
                        state_in  = ST_TBL;
                     end
                  end
               end else begin
                  build_in  = 1'b0;
                  err_in    = q_bad;
                  rd_lvl_in = TLV_W'(q_lvl);
                  rd_a_in   = IDX_W'(req_range_first);
                  rd_b_in   = IDX_W'(q_b_pos);
                  state_in  = q_bad ? ST_CMP : ST_TBL;
               end
            end
         end
         ST_TBL: begin
            state_in = ST_ELM;
         end
         ST_ELM: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (build_ff) begin
               tbl_we = 1'b1;
               if (next_pos_end <= n_wide) begin
                  rd_a_in  = rd_a_ff + IDX_W'(1);
                  rd_b_in  = rd_b_ff + IDX_W'(1);
                  state_in = ST_TBL;
               end else if ((SPW'(wr_lvl_ff) + SPW'(1) < SPW'(LEVELS))
                            && ((span << 1) <= n_wide)) begin
                  wr_lvl_in = wr_lvl_ff + TLV_W'(1);
                  rd_lvl_in = wr_lvl_ff;
                  rd_a_in   = '0;
                  rd_b_in   = IDX_W'(span);
                  state_in  = ST_TBL;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_index_in = err_ff ? '0 : strq_pkg::OUT_INDEX_W'(best_idx);
               rsp_value_in = err_ff ? '0 : strq_pkg::IN_VALUE_W'($signed(best_val));
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ready_ff      <= 1'b0;
         mode_ff       <= 1'b0;
         build_mode_ff <= 1'b0;
         build_ff      <= 1'b0;
         err_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ready_ff      <= ready_in;
         mode_ff       <= mode_in;
         build_mode_ff <= build_mode_in;
         build_ff      <= build_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_lvl_ff    <= rd_lvl_in;
      wr_lvl_ff    <= wr_lvl_in;
      rd_a_ff      <= rd_a_in;
      rd_b_ff      <= rd_b_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= VALUE_WIDTH'($signed(req_value));
      end
      va_ff <= elem_mem[ea_sel];
      vb_ff <= elem_mem[eb_sel];
      ea_ff <= ea_sel;
      eb_ff <= eb_sel;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[TAW'({wr_lvl_ff, rd_a_ff})] <= best_idx;
      end
      tda_ff <= tbl_mem[TAW'({rd_lvl_ff, rd_a_ff})];
      tdb_ff <= tbl_mem[TAW'({rd_lvl_ff, rd_b_ff})];
   end

endmodule
`default_nettype wire

/* rtl/core/strq_pick.sv */
// Shared compare unit: picks the better of two indexed elements, ties to the right.
`default_nettype none
module strq_pick #(
   parameter int unsigned IDX_W       = 10,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  wire logic                   max_mode,
   input  wire logic [IDX_W-1:0]       idx_a,
   input  wire logic [IDX_W-1:0]       idx_b,
   input  wire logic [VALUE_WIDTH-1:0] val_a,
   input  wire logic [VALUE_WIDTH-1:0] val_b,
   output logic      [IDX_W-1:0]       best_idx,
   output logic      [VALUE_WIDTH-1:0] best_val
);

   logic a_better;

   always_comb begin
      if (max_mode) begin
         a_better = $signed(val_a) > $signed(val_b);
      end else begin
         a_better = $signed(val_a) < $signed(val_b);
      end
      best_idx = a_better ? idx_a : idx_b;
      best_val = a_better ? val_a : val_b;
   end

endmodule
`default_nettype wire

/* rtl/core/strq_checker.sv */
// Port checker for the sparse table range query unit, bound to the top level.
`default_nettype none
module strq_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_stall,
   input wire logic [strq_pkg::OP_W-1:0]              req_op,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_stall,
   input wire logic [strq_pkg::OUT_INDEX_W-1:0]       rsp_best_index,
   input wire logic signed [strq_pkg::IN_VALUE_W-1:0] rsp_best_value,
   input wire logic                                   rsp_query_error,
   input wire logic                                   csr_ready
);

   logic req_fire;

   assign req_fire = req_valid && !req_stall;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_best_index)
         && $stable(rsp_best_value) && $stable(rsp_query_error))
      else $error("stalled rsp item changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall && csr_ready)
      else $error("not idle after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_query_error |-> (rsp_best_index == '0) && (rsp_best_value == '0))
      else $error("refused query carries nonzero fields");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == strq_pkg::OP_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("load item produced a result");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_op == strq_pkg::OP_QUERY) |=> req_stall && !csr_ready)
      else $error("query item did not hold off the next item");

endmodule

bind sparse_table_range_extreme_query_unit strq_checker u_strq_checker (.*);
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the sparse table range minimum/maximum query unit.
`timescale 1ns / 1ps
module tb;

   localparam int unsigned CAPACITY   = 1024;
   localparam int unsigned NUM_LEVELS = 11;
   localparam int unsigned IDLE_PCT   = 23;
   localparam int unsigned RAND_ITEMS = 1250;
   localparam int unsigned LIMIT      = 1000000;

   typedef struct {
      strq_pkg::op_type                       op;
      logic signed [strq_pkg::IN_VALUE_W-1:0] value;
      logic                                   final_value;
      logic [strq_pkg::FIRST_W-1:0]           range_first;
      logic [strq_pkg::END_W-1:0]             range_end;
   } req_item_type;

   typedef struct {
      logic [strq_pkg::OUT_INDEX_W-1:0]       index;
      logic signed [strq_pkg::IN_VALUE_W-1:0] value;
      logic                                   err;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                   req_valid       = 1'b0;
   logic                                   req_stall;
   strq_pkg::op_type                       req_op          = strq_pkg::OP_LOAD;
   logic signed [strq_pkg::IN_VALUE_W-1:0] req_value       = '0;
   logic                                   req_final_value = 1'b0;
   logic [strq_pkg::FIRST_W-1:0]           req_range_first = '0;
   logic [strq_pkg::END_W-1:0]             req_range_end   = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall       = 1'b0;
   logic [strq_pkg::OUT_INDEX_W-1:0]       rsp_best_index;
   logic signed [strq_pkg::IN_VALUE_W-1:0] rsp_best_value;
   logic                                   rsp_query_error;
   logic                                   csr_valid       = 1'b0;
   logic                                   csr_ready;
   logic                                   csr_mode        = 1'b0;

   sparse_table_range_extreme_query_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_final_value (req_final_value),
      .req_range_first (req_range_first),
      .req_range_end   (req_range_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_best_index  (rsp_best_index),
      .rsp_best_value  (rsp_best_value),
      .rsp_query_error (rsp_query_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_mode        (csr_mode)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow state of the unit
   logic signed [strq_pkg::IN_VALUE_W-1:0] arr_vals [CAPACITY];
   int unsigned                  best_pos [NUM_LEVELS][CAPACITY];
   int unsigned                  arr_len     = 0;
   logic                         table_built = 1'b0;
   logic                         built_mode  = 1'b0;
   logic                         mode_reg    = 1'b0;

   req_item_type pending [$];
   answer_type   answers [$];
   req_item_type cur_item;
   req_item_type nxt_item;
   answer_type   want;

   logic        no_gaps     = 1'b0;
   int unsigned build_wait  = 16;
   int unsigned errors      = 0;
   int unsigned cycles      = 0;
   int unsigned n_loads     = 0;
   int unsigned n_dropped   = 0;
   int unsigned n_queries   = 0;
   int unsigned n_refused   = 0;
   int unsigned n_builds    = 0;
   int unsigned n_max_builds = 0;
   int unsigned n_mode_writes = 0;

   // stimulus-side view of the array
   int unsigned gen_len    = 0;
   logic        gen_built  = 1'b0;
   int unsigned rand_items = 0;

   function automatic int unsigned keep_better(input int unsigned lhs, input int unsigned rhs);
      if (built_mode)
         return (arr_vals[lhs] > arr_vals[rhs]) ? lhs : rhs;
      return (arr_vals[lhs] < arr_vals[rhs]) ? lhs : rhs;
   endfunction

   task automatic build_windows();
      int unsigned span;
      int unsigned merges;
      merges = 0;
      built_mode = mode_reg;
      for (int unsigned p = 0; p < arr_len; p++)
         best_pos[0][p] = p;
      for (int unsigned lvl = 1; lvl < NUM_LEVELS; lvl++) begin
         span = 1 << lvl;
         if (span > arr_len)
            break;
         for (int unsigned p = 0; p + span <= arr_len; p++) begin
            best_pos[lvl][p] = keep_better(best_pos[lvl-1][p], best_pos[lvl-1][p + span/2]);
            merges++;
         end
      end
      table_built = 1'b1;
      build_wait = 4 * (merges + arr_len) + 64;
      n_builds++;
      if (built_mode)
         n_max_builds++;
   endtask

   function automatic answer_type answer_query(input logic [strq_pkg::FIRST_W-1:0] lo,
                                               input logic [strq_pkg::END_W-1:0] hi);
      answer_type  a;
      int unsigned len;
      int unsigned lvl;
      int unsigned pos;
      a.index = '0;
      a.value = '0;
      a.err   = 1'b1;
      if (!table_built || lo >= hi || hi > arr_len)
         return a;
      len = hi - lo;
      lvl = 0;
      while ((len >> (lvl + 1)) != 0)
         lvl++;
      if (lvl >= NUM_LEVELS)
         return a;
      pos = keep_better(best_pos[lvl][lo], best_pos[lvl][hi - (1 << lvl)]);
      a.index = pos[strq_pkg::OUT_INDEX_W-1:0];
      a.value = arr_vals[pos];
      a.err   = 1'b0;
      return a;
   endfunction

   task automatic take_item(input req_item_type it);
      answer_type a;
      if (it.op == strq_pkg::OP_LOAD) begin
         n_loads++;
         if (table_built) begin
            table_built = 1'b0;
            arr_len = 0;
         end
         if (arr_len < CAPACITY) begin
            arr_vals[arr_len] = it.value;
            arr_len++;
         end else begin
            n_dropped++;
         end
         if (it.final_value && arr_len != 0)
            build_windows();
      end else begin
         a = answer_query(it.range_first, it.range_end);
         answers.insert(answers.size(), a);
         n_queries++;
         if (a.err)
            n_refused++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            take_item(cur_item);
         if (pending.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
            nxt_item = pending.pop_front();
            cur_item = nxt_item;
            req_valid       <= 1'b1;
            req_op          <= nxt_item.op;
            req_value       <= nxt_item.value;
            req_final_value <= nxt_item.final_value;
            req_range_first <= nxt_item.range_first;
            req_range_end   <= nxt_item.range_end;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               $display("%0t: unexpected result index %0d value %0d error %0b", $time,
                        rsp_best_index, rsp_best_value, rsp_query_error);
               errors++;
            end else begin
               want = answers.pop_front();
               if (rsp_best_index !== want.index) begin
                  $display("%0t: best_index expected %0d actual %0d", $time,
                           want.index, rsp_best_index);
                  errors++;
               end
               if (rsp_best_value !== want.value) begin
                  $display("%0t: best_value expected %0d actual %0d", $time,
                           want.value, rsp_best_value);
                  errors++;
               end
               if (rsp_query_error !== want.err) begin
                  $display("%0t: query_error expected %0b actual %0b", $time,
                           want.err, rsp_query_error);
                  errors++;
               end
            end
         end
         rsp_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Timed out after %0d cycles, %0d results outstanding", cycles,
                  answers.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic put_load(input logic signed [strq_pkg::IN_VALUE_W-1:0] v, input logic fin);
      req_item_type it;
      it.op          = strq_pkg::OP_LOAD;
      it.value       = v;
      it.final_value = fin;
      it.range_first = strq_pkg::FIRST_W'($urandom);
      it.range_end   = strq_pkg::END_W'($urandom_range(CAPACITY));
      if (gen_built) begin
         gen_built = 1'b0;
         gen_len = 0;
      end
      if (gen_len < CAPACITY) begin
         gen_len++;
         rand_items++;
      end
      if (fin)
         gen_built = 1'b1;
      pending.insert(pending.size(), it);
   endtask

   task automatic put_query(input int unsigned lo, input int unsigned hi);
      req_item_type it;
      it.op          = strq_pkg::OP_QUERY;
      it.value       = $urandom;
      it.final_value = 1'($urandom_range(1));
      it.range_first = strq_pkg::FIRST_W'(lo);
      it.range_end   = strq_pkg::END_W'(hi);
      rand_items++;
      pending.insert(pending.size(), it);
   endtask

   task automatic put_inner_query();
      int unsigned lo;
      int unsigned hi;
      lo = $urandom_range(gen_len - 1);
      if ($urandom_range(7) == 0) begin
         lo = 0;
         hi = gen_len;
      end else begin
         hi = $urandom_range(gen_len, lo + 1);
      end
      put_query(lo, hi);
   endtask

   // drain both channels, then let any build run out
   task automatic settle();
      while (pending.size() != 0 || req_valid || answers.size() != 0)
         @(posedge clock);
      repeat (build_wait) @(posedge clock);
      build_wait = 16;
      @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_mode  <= m;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      mode_reg = m;
      n_mode_writes++;
      @(negedge clock);
   endtask

   initial begin
      int unsigned phase_no;
      int unsigned n;
      int unsigned style;
      int unsigned q;
      int          peek_at;
      logic        skip_final;
      logic signed [strq_pkg::IN_VALUE_W-1:0] v;

      phase_no = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      put_query(0, 1);
      put_load(-5, 1'b0);
      put_load(7, 1'b0);
      put_load(7, 1'b0);
      put_load(32'sh8000_0000, 1'b0);
      put_load(32'sh7fff_ffff, 1'b0);
      put_load(0, 1'b0);
      put_load(-1, 1'b0);
      put_load(7, 1'b1);
      put_query(0, 8);
      put_query(1, 3);
      put_query(3, 4);
      put_query(4, 5);
      put_query(5, 5);
      put_query(6, 2);
      put_query(0, 9);
      put_query(1023, 1024);
      settle();

      // mode change after a build must not affect the built table
      write_mode(1'b1);
      put_query(0, 8);
      put_load(3, 1'b0);
      put_query(0, 1);
      put_load(3, 1'b1);
      put_query(0, 2);
      put_query(1, 2);
      settle();

      // fill to capacity with no idling, then drop loads, the last one marked final
      write_mode(1'b0);
      no_gaps = 1'b1;
      for (int i = 0; i < CAPACITY; i++)
         put_load($urandom, 1'b0);
      put_load($urandom, 1'b0);
      put_load($urandom, 1'b0);
      put_load($urandom, 1'b1);
      put_query(0, 1024);
      put_query(1023, 1024);
      put_query(512, 1024);
      put_query(0, 1);
      repeat (28) put_inner_query();
      settle();
      no_gaps = 1'b0;

      while (rand_items < RAND_ITEMS) begin
         phase_no++;
         no_gaps = (phase_no >= 10 && phase_no < 16);
         if ($urandom_range(3) == 0)
            write_mode(1'($urandom_range(1)));
         n = $urandom_range(99);
         if (n < 70)
            n = $urandom_range(32, 1);
         else if (n < 95)
            n = $urandom_range(160, 33);
         else
            n = $urandom_range(400, 161);
         style = $urandom_range(2);
         skip_final = ($urandom_range(11) == 0);
         peek_at = ($urandom_range(9) == 0) ? int'($urandom_range(n - 1)) : -1;
         for (int i = 0; i < n; i++) begin
            if (i == peek_at)
               put_query($urandom_range(1023), $urandom_range(1024));
            case (style)
               0: v = $urandom;
               1: v = $urandom_range(4) - 2;
               default: begin
                  case ($urandom_range(4))
                     0: v = 32'sh8000_0000;
                     1: v = 32'sh7fff_ffff;
                     2: v = 0;
                     3: v = -1;
                     default: v = $urandom;
                  endcase
               end
            endcase
            put_load(v, (i == n - 1) && !skip_final);
         end
         q = $urandom_range(24, 4);
         for (int j = 0; j < q; j++) begin
            if (gen_built && $urandom_range(99) < 85)
               put_inner_query();
            else
               put_query($urandom_range(1023), $urandom_range(1024));
         end
         settle();
      end
      no_gaps = 1'b0;
      settle();

      $display("Checked %0d query results (%0d refused) against %0d loads, %0d dropped",
               n_queries, n_refused, n_loads, n_dropped);
      $display("Built the table %0d times (%0d for maximum), %0d mode writes, %0d phases",
               n_builds, n_max_builds, n_mode_writes, phase_no);
      if (errors == 0 && answers.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/strq_pkg.sv
rtl/core/strq_pick.sv
rtl/core/sparse_table_range_extreme_query_unit.sv
rtl/core/strq_checker.sv
tb/tb.sv
